@@ sv/ppu_bgtf_pkg.sv @@
// ----------------------------------------------------------------------------
// ppu_bgtf_pkg
// Shared widths, codes and address helpers for the background tile fetch.
// ----------------------------------------------------------------------------
package ppu_bgtf_pkg;

  localparam int DOT_W   = 9;
  localparam int VADDR_W = 15;
  localparam int FETCH_W = 14;
  localparam int SHIFT_W = 16;
  localparam int BYTE_W  = 8;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register indexes, taken from paddr above the byte lane bits.
  localparam logic [PADDR_W-3:0] REG_PATTERN_TABLE = 1'b0;

  // Kind of read request waiting for its reply.
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_NT   = 3'd1;
  localparam logic [2:0] KIND_ATTR = 3'd2;
  localparam logic [2:0] KIND_LOW  = 3'd3;
  localparam logic [2:0] KIND_HIGH = 3'd4;

  localparam logic [VADDR_W-1:0] FINE_Y_MASK   = 15'h7000;
  localparam logic [VADDR_W-1:0] COARSE_Y_MASK = 15'h03E0;
  localparam logic [VADDR_W-1:0] COARSE_X_MASK = 15'h001F;
  localparam logic [VADDR_W-1:0] NT_V_TOGGLE   = 15'h0800;
  localparam logic [VADDR_W-1:0] NT_H_TOGGLE   = 15'h0400;
  localparam logic [VADDR_W-1:0] HORIZ_MASK    = 15'h041F;
  localparam logic [VADDR_W-1:0] FINE_Y_STEP   = 15'h1000;
  localparam logic [FETCH_W-1:0] NT_BASE       = 14'h2000;
  localparam logic [FETCH_W-1:0] ATTR_BASE     = 14'h23C0;
  localparam logic [FETCH_W-1:0] NT_OFS_MASK   = 14'h0FFF;
  localparam logic [FETCH_W-1:0] ATTR_NT_MASK  = 14'h0C00;

  function automatic logic [VADDR_W-1:0] inc_x(input logic [VADDR_W-1:0] v);
    logic [VADDR_W-1:0] r;
    if ((v & COARSE_X_MASK) == COARSE_X_MASK) begin
      r = (v & ~COARSE_X_MASK) ^ NT_H_TOGGLE;
    end else begin
      r = v + 15'd1;
    end
    return r;
  endfunction

  function automatic logic [VADDR_W-1:0] inc_y(input logic [VADDR_W-1:0] v);
    logic [VADDR_W-1:0] w;
    logic [4:0]         y;
    w = v & ~FINE_Y_MASK;
    y = w[9:5];
    if ((v & FINE_Y_MASK) != FINE_Y_MASK) begin
      w = v + FINE_Y_STEP;
    end else begin
      if (y == 5'd29) begin
        y = 5'd0;
        w = w ^ NT_V_TOGGLE;
      end else if (y == 5'd31) begin
        y = 5'd0;
      end else begin
        y = y + 5'd1;
      end
      w = (w & ~COARSE_Y_MASK) | {5'd0, y, 5'd0};
    end
    return w;
  endfunction

endpackage

@@ sv/ppu_bgtf_in_if.sv @@
// ----------------------------------------------------------------------------
// ppu_bgtf_in_if
// Dot channel: one beat per PPU dot with v, t and the returned bus byte.
// ----------------------------------------------------------------------------
interface ppu_bgtf_in_if import ppu_bgtf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DOT_W-1:0]   dot;
  logic               render_on;
  logic [VADDR_W-1:0] vram_addr_in;
  logic [VADDR_W-1:0] temp_addr_in;
  logic [BYTE_W-1:0]  read_byte;

  modport source (output valid, dot, render_on, vram_addr_in, temp_addr_in, read_byte,
                  input ready);
  modport sink (input valid, dot, render_on, vram_addr_in, temp_addr_in, read_byte,
                output ready);
endinterface

@@ sv/ppu_bgtf_out_if.sv @@
// ----------------------------------------------------------------------------
// ppu_bgtf_out_if
// Result channel: updated v, the fetch request and the four shifters.
// ----------------------------------------------------------------------------
interface ppu_bgtf_out_if import ppu_bgtf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VADDR_W-1:0] vram_addr_out;
  logic [FETCH_W-1:0] fetch_addr;
  logic               fetch_valid;
  logic [SHIFT_W-1:0] pattern_low_shift;
  logic [SHIFT_W-1:0] pattern_high_shift;
  logic [SHIFT_W-1:0] palette_low_shift;
  logic [SHIFT_W-1:0] palette_high_shift;

  modport source (output valid, vram_addr_out, fetch_addr, fetch_valid, pattern_low_shift,
                  pattern_high_shift, palette_low_shift, palette_high_shift,
                  input ready);
  modport sink (input valid, vram_addr_out, fetch_addr, fetch_valid, pattern_low_shift,
                pattern_high_shift, palette_low_shift, palette_high_shift,
                output ready);
endinterface

@@ sv/ppu_background_tile_fetch.sv @@
// Path: an accepted dot beat passes the dot register, then the result register.
// Throughput: one dot per cycle while result.ready is not held low; the dot register
// and the result register form a two-entry pipeline, so a waiting result stops new dots once the dot register is full.
// Reset: synchronous active-high rst clears all latches, shifters, the pending
// request and the pattern table select; no clearing pass is needed.
// ----------------------------------------------------------------------------
// ppu_background_tile_fetch
// Background fetch sequencer: latches bus replies, shifts and reloads the
// pattern and palette shifters, steps loopy v and issues the next bus read.
// ----------------------------------------------------------------------------
module ppu_background_tile_fetch import ppu_bgtf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  ppu_bgtf_in_if.sink         item,
  ppu_bgtf_out_if.source      result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic                pattern_table_right;

  logic                s1_valid;
  logic [DOT_W-1:0]    s1_dot;
  logic                s1_render;
  logic [VADDR_W-1:0]  s1_v;
  logic [VADDR_W-1:0]  s1_t;
  logic [BYTE_W-1:0]   s1_rb;

  logic [BYTE_W-1:0]   tile_index_latch;
  logic [1:0]          palette_pair_latch;
  logic [BYTE_W-1:0]   low_plane_latch;
  logic [BYTE_W-1:0]   high_plane_latch;
  logic [SHIFT_W-1:0]  shifters [4];
  logic [2:0]          pending_kind;
  logic [1:0]          attr_sel;

  logic                res_valid;
  logic [VADDR_W-1:0]  res_v;
  logic [FETCH_W-1:0]  res_faddr;
  logic                res_fvalid;

  logic                advance;
  logic                step;
  logic                cfg_write;

  logic [BYTE_W-1:0]   tile_next;
  logic [1:0]          palette_next;
  logic [BYTE_W-1:0]   low_next;
  logic [BYTE_W-1:0]   high_next;
  logic [SHIFT_W-1:0]  shifters_next [4];
  logic [2:0]          kind_next;
  logic [1:0]          attr_sel_next;
  logic [VADDR_W-1:0]  v_y;
  logic [VADDR_W-1:0]  v_x;
  logic [VADDR_W-1:0]  v_next;
  logic [FETCH_W-1:0]  faddr_next;
  logic [2:0]          ph;
  logic                shift_en;
  logic                incx_en;
  logic                reload_en;
  logic                fetch_win;
  logic [4:0]          cx;
  logic [4:0]          cy;

  assign advance   = !res_valid || result.ready;
  assign step      = s1_valid && advance;
  assign item.ready = !s1_valid || advance;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_PATTERN_TABLE);
  assign prdata    = (paddr[PADDR_W-1:2] == REG_PATTERN_TABLE) ?
                     {{(PDATA_W-1){1'b0}}, pattern_table_right} : '0;

  assign ph = s1_dot[2:0];

  always_comb begin
    tile_next    = tile_index_latch;
    palette_next = palette_pair_latch;
    low_next     = low_plane_latch;
    high_next    = high_plane_latch;
    case (pending_kind)
      KIND_NT:   tile_next = s1_rb;
      KIND_ATTR: begin
        case (attr_sel)
          2'd0:    palette_next = s1_rb[1:0];
          2'd1:    palette_next = s1_rb[3:2];
          2'd2:    palette_next = s1_rb[5:4];
          default: palette_next = s1_rb[7:6];
        endcase
      end
      KIND_LOW:  low_next = s1_rb;
      KIND_HIGH: high_next = s1_rb;
      default:   ;
    endcase
  end

  always_comb begin
    shift_en  = (s1_dot >= 9'd2 && s1_dot <= 9'd257) || (s1_dot >= 9'd322 && s1_dot <= 9'd337);
    incx_en   = (ph == 3'd0 && s1_dot >= 9'd8 && s1_dot <= 9'd256) ||
                s1_dot == 9'd328 || s1_dot == 9'd336;
    reload_en = (ph == 3'd1 && s1_dot >= 9'd9 && s1_dot <= 9'd257) ||
                s1_dot == 9'd329 || s1_dot == 9'd337;
    fetch_win = (s1_dot >= 9'd1 && s1_dot <= 9'd256) || (s1_dot >= 9'd321 && s1_dot <= 9'd336);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      shifters_next[i] = shift_en ? {shifters[i][SHIFT_W-2:0], 1'b0} : shifters[i];
    end
    if (reload_en) begin
      shifters_next[0][BYTE_W-1:0] = low_next;
      shifters_next[1][BYTE_W-1:0] = high_next;
      shifters_next[2][BYTE_W-1:0] = {BYTE_W{palette_next[0]}};
      shifters_next[3][BYTE_W-1:0] = {BYTE_W{palette_next[1]}};
    end
  end

  always_comb begin
    v_y    = (s1_render && s1_dot == 9'd256) ? inc_y(s1_v) : s1_v;
    v_x    = (s1_render && incx_en) ? inc_x(v_y) : v_y;
    v_next = (s1_render && s1_dot == 9'd257) ? ((v_x & ~HORIZ_MASK) | (s1_t & HORIZ_MASK))
                                             : v_x;
  end

  always_comb begin
    cx            = v_next[4:0];
    cy            = v_next[9:5];
    kind_next     = KIND_NONE;
    faddr_next    = '0;
    attr_sel_next = attr_sel;
    if (fetch_win) begin
      case (ph)
        3'd1: begin
          kind_next  = KIND_NT;
          faddr_next = NT_BASE | (v_next[FETCH_W-1:0] & NT_OFS_MASK);
        end
        3'd3: begin
          kind_next     = KIND_ATTR;
          faddr_next    = ATTR_BASE | (v_next[FETCH_W-1:0] & ATTR_NT_MASK) |
                          {8'd0, cy[4:2], cx[4:2]};
          attr_sel_next = {cy[1], cx[1]};
        end
        3'd5: begin
          kind_next  = KIND_LOW;
          faddr_next = {1'b0, pattern_table_right, tile_next, 1'b0, v_next[14:12]};
        end
        3'd7: begin
          kind_next  = KIND_HIGH;
          faddr_next = {1'b0, pattern_table_right, tile_next, 1'b1, v_next[14:12]};
        end
        default: ;
      endcase
    end else if (s1_dot == 9'd338 || s1_dot == 9'd340) begin
      kind_next  = KIND_NT;
      faddr_next = NT_BASE | (v_next[FETCH_W-1:0] & NT_OFS_MASK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_table_right <= 1'b0;
    end else if (cfg_write) begin
      pattern_table_right <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_dot    <= item.dot;
      s1_render <= item.render_on;
      s1_v      <= item.vram_addr_in;
      s1_t      <= item.temp_addr_in;
      s1_rb     <= item.read_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_index_latch   <= '0;
      palette_pair_latch <= '0;
      low_plane_latch    <= '0;
      high_plane_latch   <= '0;
      pending_kind       <= KIND_NONE;
      attr_sel           <= '0;
      for (int i = 0; i < 4; i++) begin
        shifters[i] <= '0;
      end
    end else if (step) begin
      tile_index_latch   <= tile_next;
      palette_pair_latch <= palette_next;
      low_plane_latch    <= low_next;
      high_plane_latch   <= high_next;
      pending_kind       <= kind_next;
      attr_sel           <= attr_sel_next;
      for (int i = 0; i < 4; i++) begin
        shifters[i] <= shifters_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_v      <= v_next;
      res_faddr  <= faddr_next;
      res_fvalid <= (kind_next != KIND_NONE);
    end
  end

  assign result.valid              = res_valid;
  assign result.vram_addr_out      = res_v;
  assign result.fetch_addr         = res_faddr;
  assign result.fetch_valid        = res_fvalid;
  assign result.pattern_low_shift  = shifters[0];
  assign result.pattern_high_shift = shifters[1];
  assign result.palette_low_shift  = shifters[2];
  assign result.palette_high_shift = shifters[3];

endmodule

@@ sv/ppu_bgtf_checker.sv @@
// ----------------------------------------------------------------------------
// ppu_bgtf_checker
// Port-level checks on the background tile fetch, bound to the top level.
// ----------------------------------------------------------------------------
module ppu_bgtf_checker import ppu_bgtf_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FETCH_W-1:0] fetch_addr,
  input logic               fetch_valid,
  input logic [VADDR_W-1:0] vram_addr_out,
  input logic               pready
);

  // A stalled result beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fetch_addr) && $stable(vram_addr_out))
    else $error("result beat changed while stalled");

  // A beat without a bus request carries a zero address.
  a_idle_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fetch_valid |-> fetch_addr == '0)
    else $error("fetch address set without a request");

  // Every request lies in pattern or name-table space below 0x3000.
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && fetch_valid |-> fetch_addr[13:12] != 2'b11)
    else $error("fetch address outside the background range");

  // No result beat is shown in the cycle after reset.
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("configuration port stalled");

endmodule

bind ppu_background_tile_fetch ppu_bgtf_checker u_ppu_bgtf_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .fetch_addr    (result.fetch_addr),
  .fetch_valid   (result.fetch_valid),
  .vram_addr_out (result.vram_addr_out),
  .pready        (pready)
);
